// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released
`define HWP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define HWP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hwp_pkg.sv
package hwp_pkg;

  // Digit limit, leading zeros included
  localparam int MAX_DIGITS = 16;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int WORD_W     = 64;
  localparam int CHAR_W     = 8;

  // Parse phase codes
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_ZERO   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_TRAIL  = 3'd4;

  // Character codes of interest
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // Classification of one character
  typedef struct packed {
    logic       is_space;
    logic       is_hex;
    logic       is_zero;
    logic       is_x;
    logic [3:0] nib;
  } char_class_t;

endpackage

// File: hdl/hwp_char_class.sv
module hwp_char_class
  import hwp_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  output char_class_t       cls
);

  logic is_dec;
  logic is_lo;
  logic is_up;

  // Range decode of digits and letters
  assign is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_lo  = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
  assign is_up  = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);

  always_comb begin
    cls.is_space = (char_code == CH_SPACE) ||
                   ((char_code >= CH_TAB) && (char_code <= CH_CR));
    cls.is_hex   = is_dec || is_lo || is_up;
    cls.is_zero  = (char_code == CH_ZERO);
    cls.is_x     = (char_code == CH_LO_X) || (char_code == CH_UP_X);
    // Letters: low nibble 1..6 maps to 10..15
    if (is_dec) begin
      cls.nib = char_code[3:0];
    end else if (is_lo || is_up) begin
      cls.nib = char_code[3:0] + 4'd9;
    end else begin
      cls.nib = 4'd0;
    end
  end

endmodule

// File: hdl/hwp_step.sv
module hwp_step
  import hwp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  char_class_t       cls,
  input  logic              no_char,
  input  logic              last,
  output logic              ok,
  output logic [WORD_W-1:0] word
);

  logic [2:0]        phase_r,  phase_nxt;
  logic [WORD_W-1:0] accum_r,  accum_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic              failed_r, failed_nxt;

  // One character of the state update
  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    cnt_nxt    = cnt_r;
    failed_nxt = failed_r;
    if (!no_char && !failed_r) begin
      case (phase_r)
        PH_LEAD, PH_ZERO, PH_PREFIX, PH_DIGITS: begin
          if ((phase_r == PH_LEAD) && cls.is_space) begin
            // still skipping leading blanks
          end else if ((phase_r == PH_LEAD) && cls.is_zero) begin
            cnt_nxt   = CNT_W'(1);
            accum_nxt = '0;
            phase_nxt = PH_ZERO;
          end else if ((phase_r == PH_ZERO) && cls.is_x) begin
            cnt_nxt   = '0;
            accum_nxt = '0;
            phase_nxt = PH_PREFIX;
          end else if (cls.is_hex) begin
            // digit limit reached: reject, count holds
            if (cnt_r == CNT_W'(MAX_DIGITS)) begin
              failed_nxt = 1'b1;
            end else begin
              cnt_nxt   = cnt_r + CNT_W'(1);
              accum_nxt = {accum_r[WORD_W-5:0], cls.nib};
              phase_nxt = PH_DIGITS;
            end
          end else if (cls.is_space &&
                       ((phase_r == PH_ZERO) || (phase_r == PH_DIGITS))) begin
            phase_nxt = PH_TRAIL;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (!cls.is_space) begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  // Verdict on the end of the string
  assign ok = !failed_nxt && (cnt_nxt != '0) &&
              ((phase_nxt == PH_ZERO) || (phase_nxt == PH_DIGITS) ||
               (phase_nxt == PH_TRAIL));
  assign word = ok ? accum_nxt : '0;

  // Parse state; the last item returns to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      accum_r  <= '0;
      cnt_r    <= '0;
      failed_r <= 1'b0;
    end else if (en) begin
      if (last) begin
        phase_r  <= PH_LEAD;
        accum_r  <= '0;
        cnt_r    <= '0;
        failed_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        accum_r  <= accum_nxt;
        cnt_r    <= cnt_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

endmodule

// File: hdl/hex_word_text_parser_core.sv
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle unless stalled; results only on tlast.
// The input register and the result register each hold one request, so the
// input side stalls only while a result waits and the input register is full.
// Reset: rst_n synchronous, active low; clears both valid flags and parse state.
module hex_word_text_parser_core
  import hwp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic [0:0]        in_tuser,   // [0] no_char
  input  logic              in_tlast,   // last
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // [63:0] word
  output logic [0:0]        out_tuser   // [0] ok
);

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_nochar_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic              out_ok_r;
  logic              out_free;
  logic              s1_go;
  logic              in_fire;
  char_class_t       cls;
  logic              step_ok;
  logic [WORD_W-1:0] step_word;

  // Handshake control
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r   <= in_tdata;
      s1_nochar_r <= in_tuser[0];
      s1_last_r   <= in_tlast;
    end
  end

  hwp_char_class u_class (
    .char_code (s1_char_r),
    .cls       (cls)
  );

  hwp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_go),
    .cls     (cls),
    .no_char (s1_nochar_r),
    .last    (s1_last_r),
    .ok      (step_ok),
    .word    (step_word)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_word_r <= step_word;
      out_ok_r   <= step_ok;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_word_r;
  assign out_tuser[0] = out_ok_r;

endmodule

// File: hdl/hwp_checker.sv
`include "assert_macros.svh"

module hwp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic        out_stall;
  logic        out_reject;
  logic [65:0] out_held;

  // Output side views used by the properties
  assign out_stall  = out_tvalid && !out_tready;
  assign out_reject = out_tvalid && !out_tuser[0];
  assign out_held   = {out_tvalid, out_tuser, out_tdata};

  // A stalled result stays valid and holds its payload
  `HWP_ASSERT(a_out_hold, clk, rst_n, out_stall |=> $stable(out_held), "stalled result changed")

  // A rejected string reports a zero word
  `HWP_ASSERT(a_reject_zero, clk, rst_n, out_reject |-> out_tdata == '0, "nonzero rejected word")

  // With no result pending the input side is never stalled
  `HWP_ASSERT(a_ready_free, clk, rst_n, !out_tvalid |-> in_tready, "input stalled, output empty")

  // Reset leaves no result pending
  `HWP_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind hex_word_text_parser_core hwp_checker u_hwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench
  import hwp_pkg::*;
();

  // One text request as it travels on the input stream
  typedef struct packed {
    logic [7:0] ch;
    logic       nc;
    logic       lst;
  } text_req_t;

  // One parse result
  typedef struct packed {
    logic        ok;
    logic [63:0] word;
  } word_result_t;

  // Directed row: request plus a hand-typed result where it is obvious
  typedef struct packed {
    logic [7:0]  ch;
    logic        nc;
    logic        lst;
    logic        typed;
    logic        ok;
    logic [63:0] word;
  } text_row_t;

  localparam int DIR_ROWS   = 23;
  localparam int RAND_ITEMS = 1600;
  localparam int LONG_HOLD  = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  // Parser shadow state
  logic [2:0]       pr_phase;
  logic [63:0]      pr_accum;
  logic [CNT_W-1:0] pr_count;
  logic             pr_failed;

  word_result_t pending_words[$];
  text_req_t    text_buf[$];
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           burst_left = 0;
  bit           hold_done = 1'b0;

  // Directed strings; ch, nc, lst, typed, ok, word
  text_row_t text_table [DIR_ROWS] = '{
    '{8'h00,    1, 1, 1, 0, 0},  // empty string
    '{CH_ZERO,  0, 1, 1, 1, 0},  // lone zero
    '{CH_ZERO,  0, 0, 0, 0, 0},
    '{CH_UP_X,  0, 1, 1, 0, 0},  // prefix with no digits
    '{CH_TAB,   0, 0, 0, 0, 0},
    '{CH_ZERO,  0, 0, 0, 0, 0},
    '{CH_LO_X,  0, 0, 0, 0, 0},
    '{CH_LO_A,  0, 0, 0, 0, 0},
    '{CH_UP_F,  0, 0, 0, 0, 0},
    '{CH_SPACE, 0, 0, 0, 0, 0},
    '{8'h00,    1, 1, 0, 0, 0},  // ends on an empty request
    '{8'hFF,    0, 1, 1, 0, 0},  // top byte is not a digit
    '{8'hA5,    1, 0, 0, 0, 0},  // ignored request
    '{8'h37,    0, 1, 0, 0, 0},
    '{8'h31,    0, 0, 0, 0, 0},
    '{CH_SPACE, 0, 0, 0, 0, 0},
    '{8'h32,    0, 1, 1, 0, 0},  // space inside the digits
    '{CH_ZERO,  0, 0, 0, 0, 0},
    '{CH_CR,    0, 1, 0, 0, 0},
    '{CH_ZERO,  0, 0, 0, 0, 0},
    '{CH_LO_X,  0, 0, 0, 0, 0},
    '{CH_SPACE, 0, 1, 1, 0, 0},  // space right after the prefix
    '{8'h0B,    0, 1, 1, 0, 0}   // whitespace only
  };

  hex_word_text_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // 0..15 for a hex digit, 16 otherwise
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, c[3:0]};
    if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [7:0] ws_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 15);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + v - 10);
  endfunction

  task automatic clear_parse();
    pr_phase  = PH_LEAD;
    pr_accum  = '0;
    pr_count  = '0;
    pr_failed = 1'b0;
  endtask

  task automatic add_digit(input logic [3:0] d);
    pr_count = pr_count + 1'b1;
    if (pr_count > MAX_DIGITS) begin
      pr_failed = 1'b1;
    end else begin
      pr_accum = {pr_accum[59:0], d};
      pr_phase = PH_DIGITS;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [4:0] d;
    logic       sp;
    d  = hex_value(c);
    sp = is_ws(c);
    if (!pr_failed) begin
      case (pr_phase)
        PH_LEAD: begin
          if (!sp) begin
            if (c == CH_ZERO) begin
              pr_count = CNT_W'(1);
              pr_accum = '0;
              pr_phase = PH_ZERO;
            end else if (d < 16) add_digit(d[3:0]);
            else pr_failed = 1'b1;
          end
        end
        // held zero: prefix, lone zero, or first digit
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            pr_count = '0;
            pr_accum = '0;
            pr_phase = PH_PREFIX;
          end else if (sp) pr_phase = PH_TRAIL;
          else if (d < 16) add_digit(d[3:0]);
          else pr_failed = 1'b1;
        end
        PH_PREFIX, PH_DIGITS: begin
          if (d < 16) add_digit(d[3:0]);
          else if (sp && pr_phase == PH_DIGITS) pr_phase = PH_TRAIL;
          else pr_failed = 1'b1;
        end
        PH_TRAIL: begin
          if (!sp) pr_failed = 1'b1;
        end
        default: pr_failed = 1'b1;
      endcase
    end
  endtask

  task automatic predict_word(input text_req_t r, output logic got, output word_result_t res);
    logic okv;
    got = 1'b0;
    res = '0;
    if (!r.nc) parse_char(r.ch);
    if (r.lst) begin
      okv = !pr_failed && pr_count >= 1 &&
            (pr_phase == PH_ZERO || pr_phase == PH_DIGITS || pr_phase == PH_TRAIL);
      res.ok   = okv;
      res.word = okv ? pr_accum : 64'd0;
      got      = 1'b1;
      clear_parse();
    end
  endtask

  // Offer one request in bursts, wait for it to be taken, then predict
  task automatic send_req(input text_req_t r, input logic typed, input word_result_t typed_res);
    int           gap;
    logic         got;
    word_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= r.ch;
    in_tuser  <= r.nc;
    in_tlast  <= r.lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(r, got, res);
    if (got) pending_words.insert(pending_words.size(), typed ? typed_res : res);
  endtask

  // Hold the input idle until every pending result is back
  task automatic drain_words();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic add_text_char(input logic [7:0] c);
    text_req_t r;
    r.ch  = c;
    r.nc  = 1'b0;
    r.lst = 1'b0;
    text_buf.insert(text_buf.size(), r);
  endtask

  // Mostly well-formed words, some corrupted, some noise
  task automatic build_random_text();
    int        kind;
    int        n_dig;
    int        pos;
    text_req_t r;
    text_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind < 9) begin
      repeat ($urandom_range(0, 2)) add_text_char(ws_char());
      if ($urandom_range(0, 1)) begin
        add_text_char(CH_ZERO);
        add_text_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      end
      pos = $urandom_range(0, 19);
      if (pos == 0) n_dig = 0;
      else if (pos < 4) n_dig = $urandom_range(16, 18);
      else n_dig = $urandom_range(1, 16);
      repeat (n_dig) add_text_char(hex_char());
      repeat ($urandom_range(0, 2)) add_text_char(ws_char());
      // corrupt one position
      if (kind >= 7 && text_buf.size() != 0) begin
        pos = $urandom_range(0, text_buf.size() - 1);
        text_buf[pos].ch = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255));
      end
    end else begin
      repeat ($urandom_range(1, 6)) add_text_char(8'($urandom_range(0, 255)));
    end
    // ignored empty request somewhere in the string
    if ($urandom_range(0, 3) == 0) begin
      r.ch  = 8'($urandom_range(0, 255));
      r.nc  = 1'b1;
      r.lst = 1'b0;
      text_buf.insert($urandom_range(0, text_buf.size()), r);
    end
    if (text_buf.size() == 0 || $urandom_range(0, 2) == 0) begin
      r.ch  = 8'($urandom_range(0, 255));
      r.nc  = 1'b1;
      r.lst = 1'b1;
      text_buf.insert(text_buf.size(), r);
    end else begin
      text_buf[text_buf.size() - 1].lst = 1'b1;
    end
  endtask

  // Stimulus
  initial begin : stim
    text_req_t    r;
    word_result_t w;
    int           counted;
    bit           paused;
    clear_parse();
    counted = 0;
    paused  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      r.ch    = text_table[i].ch;
      r.nc    = text_table[i].nc;
      r.lst   = text_table[i].lst;
      w.ok    = text_table[i].ok;
      w.word  = text_table[i].word;
      send_req(r, text_table[i].typed, w);
    end
    drain_words();

    while (counted < RAND_ITEMS) begin
      build_random_text();
      foreach (text_buf[k]) begin
        send_req(text_buf[k], 1'b0, '0);
        if (!text_buf[k].nc || text_buf[k].lst) counted++;
      end
      if (!paused && counted >= RAND_ITEMS / 2) begin
        drain_words();
        paused = 1'b1;
      end
    end
    in_tvalid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("results never arrived: %0d", pending_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off once results are flowing
  initial begin : rx_pattern
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= 40) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (left % 4 == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result check against the oldest pending word
  always @(posedge clk) begin : result_check
    word_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected result: ok %0d word %h", out_tuser[0], out_tdata);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_tuser[0] !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tdata !== want.word) begin
          $error("word: expected %h, actual %h", want.word, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

endmodule

// File: files.f
+incdir+hdl
hdl/hwp_pkg.sv
hdl/hwp_char_class.sv
hdl/hwp_step.sv
hdl/hex_word_text_parser_core.sv
hdl/hwp_checker.sv
tb/testbench.sv
